>>> rtl/core/mbsp_pkg.sv
// package for the midi byte stream parser: result kinds, sysex limit and widths
// no dependencies
package mbsp_pkg;

	// largest number of sysex bytes counted before the message is closed
	localparam int unsigned SYSEX_MAX = 256;
	localparam int unsigned SYSEX_CNT_W = $clog2(SYSEX_MAX + 1);

	// field widths of one result
	localparam int unsigned KIND_W = 2;
	localparam int unsigned NIB_W = 4;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 9;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHANNEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SYSTEM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SYSEX_DONE = 2'd2;

	// byte codes
	localparam logic [BYTE_W-1:0] BYTE_SYSEX_START = 8'hF0;
	localparam logic [BYTE_W-1:0] BYTE_SYSEX_END = 8'hF7;
	localparam logic [NIB_W-1:0] CMD_PROG_CHANGE = 4'hC;
	localparam logic [NIB_W-1:0] CMD_CHAN_PRESSURE = 4'hD;
	localparam logic [NIB_W-1:0] CMD_SYSTEM = 4'hF;

	// sysex count to the length field, saturating when it does not fit
	function automatic logic [LEN_W-1:0] sat_len(input logic [SYSEX_CNT_W-1:0] cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		if (wide > 32'((1 << LEN_W) - 1))
			return {LEN_W{1'b1}};
		return wide[LEN_W-1:0];
	endfunction

endpackage

>>> rtl/core/mbsp_if.sv
// request channels of the midi byte stream parser: received bytes and parsed messages
// depends on mbsp_pkg
interface mbsp_byte_if import mbsp_pkg::*; ();
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbsp_msg_if import mbsp_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] msg_kind;
	logic [NIB_W-1:0] msg_command;
	logic [NIB_W-1:0] msg_channel;
	logic [BYTE_W-1:0] data_first;
	logic [BYTE_W-1:0] data_second;
	logic [LEN_W-1:0] sysex_length;

	modport source (output valid, output msg_kind, output msg_command, output msg_channel,
		output data_first, output data_second, output sysex_length, input ready);
	modport sink (input valid, input msg_kind, input msg_command, input msg_channel,
		input data_first, input data_second, input sysex_length, output ready);
endinterface

>>> rtl/core/midi_byte_stream_parser_unit.sv
// midi byte stream parser: groups received bytes into channel, system and sysex messages
// depends on mbsp_pkg and the channel interfaces in mbsp_if.sv
//
// a message's last byte passes the input register, then its result enters the result register
// throughput: one byte per cycle while the result side takes requests
// the parse state and the result register advance as a byte leaves the input register
// reset: asynchronous, clears the parse phase, held bytes, sysex count and both valid flags
module midi_byte_stream_parser_unit import mbsp_pkg::*; (
	input logic clk,
	input logic arst_n,
	mbsp_byte_if.sink rx,
	mbsp_msg_if.source msg
);

	// parse phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DATA1 = 2'd1;
	localparam logic [1:0] PH_DATA2 = 2'd2;
	localparam logic [1:0] PH_SYSEX = 2'd3;

	// input register
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parse state
	logic [1:0] phase_q;
	logic [BYTE_W-1:0] status_q;
	logic [BYTE_W-1:0] first_q;
	logic [SYSEX_CNT_W-1:0] count_q;

	// result register
	logic out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [NIB_W-1:0] cmd_q;
	logic [NIB_W-1:0] chan_q;
	logic [BYTE_W-1:0] d1_q;
	logic [BYTE_W-1:0] d2_q;
	logic [LEN_W-1:0] len_q;

	// next state and result
	logic go;
	logic [1:0] phase_d;
	logic [BYTE_W-1:0] status_d;
	logic [BYTE_W-1:0] first_d;
	logic [SYSEX_CNT_W-1:0] count_d;
	logic [SYSEX_CNT_W-1:0] count_inc;
	logic emit;
	logic [KIND_W-1:0] kind_d;
	logic [NIB_W-1:0] cmd_d;
	logic [NIB_W-1:0] chan_d;
	logic [BYTE_W-1:0] d1_d;
	logic [BYTE_W-1:0] d2_d;
	logic [LEN_W-1:0] len_d;
	logic [NIB_W-1:0] held_cmd;

	// the registered byte moves on when the result slot is free or being emptied
	assign go = valid_s1 && (!out_valid_q || msg.ready);
	assign rx.ready = !valid_s1 || go;
	assign held_cmd = status_q[BYTE_W-1 -: NIB_W];
	assign count_inc = count_q + 1'b1;

	// parse one byte
	always_comb begin
		phase_d = phase_q;
		status_d = status_q;
		first_d = first_q;
		count_d = count_q;
		emit = 1'b0;
		kind_d = KIND_CHANNEL;
		cmd_d = held_cmd;
		chan_d = status_q[NIB_W-1:0];
		d1_d = '0;
		d2_d = '0;
		len_d = '0;
		case (phase_q)
			PH_IDLE: begin
				if (byte_s1[BYTE_W-1]) begin
					if (byte_s1[BYTE_W-1 -: NIB_W] != CMD_SYSTEM) begin
						status_d = byte_s1;
						phase_d = PH_DATA1;
					end else if (byte_s1 != BYTE_SYSEX_START) begin
						emit = 1'b1;
						kind_d = KIND_SYSTEM;
						cmd_d = CMD_SYSTEM;
						chan_d = byte_s1[NIB_W-1:0];
					end else begin
						count_d = '0;
						phase_d = PH_SYSEX;
					end
				end
			end
			PH_DATA1: begin
				if (held_cmd == CMD_PROG_CHANGE || held_cmd == CMD_CHAN_PRESSURE) begin
					emit = 1'b1;
					d1_d = byte_s1;
					phase_d = PH_IDLE;
				end else begin
					first_d = byte_s1;
					phase_d = PH_DATA2;
				end
			end
			PH_DATA2: begin
				emit = 1'b1;
				d1_d = first_q;
				d2_d = byte_s1;
				phase_d = PH_IDLE;
			end
			default: begin
				// sysex skipping: terminator or full buffer closes it
				cmd_d = CMD_SYSTEM;
				chan_d = '0;
				kind_d = KIND_SYSEX_DONE;
				if (byte_s1 == BYTE_SYSEX_END) begin
					emit = 1'b1;
					len_d = sat_len(count_q);
					phase_d = PH_IDLE;
				end else begin
					count_d = count_inc;
					if (32'(count_inc) >= 32'(SYSEX_MAX)) begin
						emit = 1'b1;
						len_d = sat_len(count_inc);
						phase_d = PH_IDLE;
					end
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			status_q <= '0;
			first_q <= '0;
			count_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			status_q <= status_d;
			first_q <= first_d;
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= emit;
		end else if (msg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			kind_q <= kind_d;
			cmd_q <= cmd_d;
			chan_q <= chan_d;
			d1_q <= d1_d;
			d2_q <= d2_d;
			len_q <= len_d;
		end
	end

	assign msg.valid = out_valid_q;
	assign msg.msg_kind = kind_q;
	assign msg.msg_command = cmd_q;
	assign msg.msg_channel = chan_q;
	assign msg.data_first = d1_q;
	assign msg.data_second = d2_q;
	assign msg.sysex_length = len_q;

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for midi_byte_stream_parser_unit: directed table of bytes and results,
// then random traffic checked against an in-bench parser model, random stalls on both sides
// depends on mbsp_pkg, the request interfaces in mbsp_if.sv and the parser top level
module testbench;
	import mbsp_pkg::*;

	// one parsed message as the result side presents it
	typedef struct packed {
		logic [KIND_W-1:0] msg_kind;
		logic [NIB_W-1:0] msg_command;
		logic [NIB_W-1:0] msg_channel;
		logic [BYTE_W-1:0] data_first;
		logic [BYTE_W-1:0] data_second;
		logic [LEN_W-1:0] sysex_length;
	} midi_msg_t;

	// one row of the directed byte table
	typedef struct {
		logic [BYTE_W-1:0] rx_value;
		bit has_msg;
		midi_msg_t msg;
	} byte_row_t;

	typedef enum logic [1:0] {
		WAIT_STATUS,
		WAIT_DATA1,
		WAIT_DATA2,
		SKIP_SYSEX
	} parse_phase_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mbsp_byte_if rx_ch ();
	mbsp_msg_if msg_ch ();

	midi_byte_stream_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.msg(msg_ch)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state of the parser
	parse_phase_e model_phase;
	logic [BYTE_W-1:0] model_status;
	logic [BYTE_W-1:0] model_first;
	int unsigned model_sysex_cnt;

	midi_msg_t pending_msgs[$];
	int unsigned bytes_sent;
	int unsigned msgs_expected;
	int unsigned msgs_checked;
	int unsigned mismatches;
	int unsigned long_sysex_cnt;
	bit rx_steady;
	bit msg_steady;

	function automatic logic [LEN_W-1:0] len_field(input int unsigned n);
		if (n > (1 << LEN_W) - 1)
			return {LEN_W{1'b1}};
		return n[LEN_W-1:0];
	endfunction

	// advance the parser model by one accepted byte; returns 1 when a message results
	function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output midi_msg_t m);
		logic [NIB_W-1:0] cmd;
		logic [NIB_W-1:0] chan;
		cmd = model_status[7:4];
		chan = model_status[3:0];
		m = '0;
		m.msg_command = CMD_SYSTEM;
		m.msg_kind = KIND_SYSEX_DONE;
		case (model_phase)
			WAIT_STATUS: begin
				// data bytes are dropped while idle
				if (!b[7])
					return 1'b0;
				if (b[7:4] != CMD_SYSTEM) begin
					model_status = b;
					model_phase = WAIT_DATA1;
					return 1'b0;
				end
				if (b != BYTE_SYSEX_START) begin
					m.msg_kind = KIND_SYSTEM;
					m.msg_channel = b[3:0];
					return 1'b1;
				end
				model_sysex_cnt = 0;
				if (SYSEX_MAX < 1)
					return 1'b1;
				model_phase = SKIP_SYSEX;
				return 1'b0;
			end
			WAIT_DATA1: begin
				if (cmd == CMD_PROG_CHANGE || cmd == CMD_CHAN_PRESSURE) begin
					model_phase = WAIT_STATUS;
					m.msg_kind = KIND_CHANNEL;
					m.msg_command = cmd;
					m.msg_channel = chan;
					m.data_first = b;
					return 1'b1;
				end
				model_first = b;
				model_phase = WAIT_DATA2;
				return 1'b0;
			end
			WAIT_DATA2: begin
				model_phase = WAIT_STATUS;
				m.msg_kind = KIND_CHANNEL;
				m.msg_command = cmd;
				m.msg_channel = chan;
				m.data_first = model_first;
				m.data_second = b;
				return 1'b1;
			end
			default: begin
				// every byte but the terminator is counted, status bytes too
				if (b == BYTE_SYSEX_END) begin
					model_phase = WAIT_STATUS;
					m.sysex_length = len_field(model_sysex_cnt);
					return 1'b1;
				end
				model_sysex_cnt++;
				if (model_sysex_cnt >= SYSEX_MAX) begin
					model_phase = WAIT_STATUS;
					m.sysex_length = len_field(model_sysex_cnt);
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	// gap length: mostly none or short, a few long, with stretches of none
	function automatic int unsigned pick_gap(inout bit steady);
		int unsigned r;
		if ($urandom_range(0, 149) == 0)
			steady = !steady;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic string msg_text(input midi_msg_t m);
		return $sformatf("kind=%0d cmd=%h chan=%h d1=%h d2=%h len=%0d", m.msg_kind,
			m.msg_command, m.msg_channel, m.data_first, m.data_second, m.sysex_length);
	endfunction

	function automatic byte_row_t row(input logic [BYTE_W-1:0] v);
		byte_row_t r;
		r.rx_value = v;
		r.has_msg = 1'b0;
		r.msg = '0;
		return r;
	endfunction

	function automatic byte_row_t row_msg(input logic [BYTE_W-1:0] v, input midi_msg_t m);
		byte_row_t r;
		r.rx_value = v;
		r.has_msg = 1'b1;
		r.msg = m;
		return r;
	endfunction

	// present one byte, wait for its request to be taken, then update the model
	task automatic send_rx(input logic [BYTE_W-1:0] b, input bit typed, input midi_msg_t typed_msg);
		midi_msg_t m;
		bit got;
		int unsigned gap;
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		got = parse_rx_byte(b, m);
		bytes_sent++;
		if (typed) begin
			pending_msgs.push_back(typed_msg);
			msgs_expected++;
		end else if (got) begin
			pending_msgs.push_back(m);
			msgs_expected++;
		end
		gap = pick_gap(rx_steady);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_plain(input logic [BYTE_W-1:0] b);
		send_rx(b, 1'b0, '0);
	endtask

	// data byte, usually in range, now and then any value
	function automatic logic [BYTE_W-1:0] pick_data();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	// sysex body byte: anything but the terminator
	function automatic logic [BYTE_W-1:0] pick_body();
		logic [BYTE_W-1:0] v;
		v = 8'($urandom_range(0, 255));
		if (v == BYTE_SYSEX_END)
			v = v ^ 8'h01;
		return v;
	endfunction

	// random message traffic until the item budget is used
	task automatic send_traffic(input int unsigned budget);
		int unsigned start;
		int unsigned r;
		int unsigned n;
		logic [NIB_W-1:0] cmd;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				cmd = 4'($urandom_range(8, 14));
				send_plain({cmd, 4'($urandom_range(0, 15))});
				n = (cmd == CMD_PROG_CHANGE || cmd == CMD_CHAN_PRESSURE) ? 1 : 2;
				repeat (n) send_plain(pick_data());
			end else if (r < 72) begin
				send_plain({CMD_SYSTEM, 4'($urandom_range(1, 15))});
			end else if (r < 86 || long_sysex_cnt >= 5) begin
				send_plain(BYTE_SYSEX_START);
				n = $urandom_range(0, 12);
				repeat (n) send_plain(pick_body());
				if (r < 86 || $urandom_range(0, 3) != 0)
					send_plain(BYTE_SYSEX_END);
				else
					repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(0, 255)));
			end else if (r < 89) begin
				// long sysex around the buffer limit; past it the stream is parsed afresh
				long_sysex_cnt++;
				send_plain(BYTE_SYSEX_START);
				n = $urandom_range(250, 262);
				repeat ((n < SYSEX_MAX) ? n : SYSEX_MAX) send_plain(pick_body());
				if (n < SYSEX_MAX || $urandom_range(0, 1) == 1)
					send_plain(BYTE_SYSEX_END);
			end else begin
				repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// result side: ready with random stalls
	initial begin
		int unsigned hold;
		msg_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			msg_ch.ready <= 1'b1;
			hold = $urandom_range(1, 12);
			repeat (hold) @(posedge clk);
			hold = pick_gap(msg_steady);
			if (hold > 0) begin
				msg_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// compare every taken result request with the oldest expected message
	always @(posedge clk) begin
		midi_msg_t got;
		midi_msg_t want;
		if (arst_n && msg_ch.valid && msg_ch.ready) begin
			got.msg_kind = msg_ch.msg_kind;
			got.msg_command = msg_ch.msg_command;
			got.msg_channel = msg_ch.msg_channel;
			got.data_first = msg_ch.data_first;
			got.data_second = msg_ch.data_second;
			got.sysex_length = msg_ch.sysex_length;
			if (pending_msgs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected message: %s", $realtime, msg_text(got));
			end else begin
				want = pending_msgs.pop_front();
				msgs_checked++;
				if (got.msg_kind !== want.msg_kind || got.msg_command !== want.msg_command
						|| got.msg_channel !== want.msg_channel
						|| got.data_first !== want.data_first
						|| got.data_second !== want.data_second
						|| got.sysex_length !== want.sysex_length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] message mismatch\n  expected %s\n  actual   %s",
							$realtime, msg_text(want), msg_text(got));
				end
			end
		end
	end

	// main sequence
	initial begin
		byte_row_t directed[$];
		int unsigned settle;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		model_phase = WAIT_STATUS;
		model_status = '0;
		model_first = '0;
		model_sysex_cnt = 0;
		bytes_sent = 0;
		msgs_expected = 0;
		msgs_checked = 0;
		mismatches = 0;
		long_sysex_cnt = 0;
		rx_steady = 1'b0;
		msg_steady = 1'b0;

		// data bytes while idle are dropped
		directed.push_back(row(8'h00));
		directed.push_back(row(8'h7F));
		// note on, channel 0
		directed.push_back(row(8'h90));
		directed.push_back(row(8'h3C));
		directed.push_back(row_msg(8'h7F, '{KIND_CHANNEL, 4'h9, 4'h0, 8'h3C, 8'h7F, 9'd0}));
		// note off, channel 15, zero data
		directed.push_back(row(8'h8F));
		directed.push_back(row(8'h00));
		directed.push_back(row_msg(8'h00, '{KIND_CHANNEL, 4'h8, 4'hF, 8'h00, 8'h00, 9'd0}));
		// one-byte commands
		directed.push_back(row(8'hC5));
		directed.push_back(row_msg(8'h7F, '{KIND_CHANNEL, CMD_PROG_CHANGE, 4'h5, 8'h7F, 8'h00,
			9'd0}));
		directed.push_back(row(8'hDA));
		directed.push_back(row_msg(8'hFF, '{KIND_CHANNEL, CMD_CHAN_PRESSURE, 4'hA, 8'hFF, 8'h00,
			9'd0}));
		// status bytes in data position are taken as data
		directed.push_back(row(8'hE3));
		directed.push_back(row(8'hF8));
		directed.push_back(row_msg(8'h80, '{KIND_CHANNEL, 4'hE, 4'h3, 8'hF8, 8'h80, 9'd0}));
		// system messages, including a stray terminator while idle
		directed.push_back(row_msg(8'hF8, '{KIND_SYSTEM, CMD_SYSTEM, 4'h8, 8'h00, 8'h00, 9'd0}));
		directed.push_back(row_msg(8'hFF, '{KIND_SYSTEM, CMD_SYSTEM, 4'hF, 8'h00, 8'h00, 9'd0}));
		directed.push_back(row_msg(8'hF7, '{KIND_SYSTEM, CMD_SYSTEM, 4'h7, 8'h00, 8'h00, 9'd0}));
		// sysex with a status byte inside, then an empty sysex
		directed.push_back(row(BYTE_SYSEX_START));
		directed.push_back(row(8'h01));
		directed.push_back(row(8'h90));
		directed.push_back(row_msg(BYTE_SYSEX_END, '{KIND_SYSEX_DONE, CMD_SYSTEM, 4'h0, 8'h00,
			8'h00, 9'd2}));
		directed.push_back(row(BYTE_SYSEX_START));
		directed.push_back(row_msg(BYTE_SYSEX_END, '{KIND_SYSEX_DONE, CMD_SYSTEM, 4'h0, 8'h00,
			8'h00, 9'd0}));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_rx(directed[i].rx_value, directed[i].has_msg, directed[i].msg);

		// a sysex that fills the buffer, then random traffic
		long_sysex_cnt++;
		send_plain(BYTE_SYSEX_START);
		repeat (SYSEX_MAX) send_plain(pick_body());
		send_traffic(1400);

		// drain the result side, then give the pipeline time to show stray messages
		rx_ch.valid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		settle = 10;
		repeat (settle) @(posedge clk);

		$display("sent %0d bytes, checked %0d of %0d expected messages, %0d long sysex",
			bytes_sent, msgs_checked, msgs_expected, long_sysex_cnt);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("run limit reached with %0d messages outstanding", pending_msgs.size());
		$display("testbench failed");
		$finish;
	end

endmodule
